// ----- hw/rtl/atss_pkg.sv -----
// Types and codes shared by the bounded array engine.
// No dependencies.
package atss_pkg;
  localparam int ActW = 3;
  localparam int ValW = 32;
  localparam int PosW = 11;
  localparam int StatW = 2;

  typedef enum logic [ActW-1:0] {
    ACT_APPEND  = 3'd0,
    ACT_INSERT  = 3'd1,
    ACT_REMOVE  = 3'd2,
    ACT_READ    = 3'd3,
    ACT_LSEARCH = 3'd4,
    ACT_BSEARCH = 3'd5,
    ACT_SORT    = 3'd6,
    ACT_CHECK   = 3'd7
  } action_t;

  typedef enum logic [StatW-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_RANGE    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;
endpackage

// ----- hw/rtl/atss_if.sv -----
// Request and result channels with valid/ready handshake.
// Depends on atss_pkg.
interface atss_req_if import atss_pkg::*; ();
  logic valid;
  logic ready;
  logic [ActW-1:0] action;
  logic signed [ValW-1:0] value;
  logic [PosW-1:0] position;
  modport source (output valid, action, value, position, input ready);
  modport sink (input valid, action, value, position, output ready);
endinterface

interface atss_rsp_if import atss_pkg::*; ();
  logic valid;
  logic ready;
  logic [StatW-1:0] status;
  logic signed [ValW-1:0] read_value;
  logic [PosW-1:0] found_position;
  logic flag;
  logic [PosW-1:0] count;
  modport source (output valid, status, read_value, found_position, flag, count,
                  input ready);
  modport sink (input valid, status, read_value, found_position, flag, count,
                output ready);
endinterface

// ----- hw/rtl/atss_mem.sv -----
// Element store: one write port, one read port, registered read data.
// Depends on atss_pkg.
module atss_mem import atss_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int AW = 10
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [AW-1:0]          waddr,
  input  logic [ValW-1:0]        wdata,
  input  logic [AW-1:0]          raddr,
  output logic [ValW-1:0]        rdata
);
  logic [ValW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- hw/rtl/array_table_sort_search_engine.sv -----
// Bounded array engine: append, insert, remove, read, searches, sort, check.
// One request at a time; the next is accepted in the cycle after the result is taken.
// Append and read finish without walking the store. Insert, remove, check and
// linear search walk the elements one by one; binary search halves the range
// per probe. Sort is an insertion sort that moves elements one place at a time.
// Reset clears the count and returns to idle; the store needs no clearing pass.
module array_table_sort_search_engine import atss_pkg::*; #(
  parameter int DEPTH = 1024
) (
  input logic clk,
  input logic rst,
  atss_req_if.sink req,
  atss_rsp_if.source rsp
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = ($clog2(DEPTH + 1) > PosW) ? $clog2(DEPTH + 1) : PosW;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_RD, S_WAIT, S_SHIFT_RD, S_SHIFT_WR, S_LS, S_BS,
    S_SORT_CUR, S_SORT_CMP, S_CHK, S_DONE
  } state_t;

  state_t state;
  action_t act;
  logic signed [ValW-1:0] key;
  logic [CW-1:0] pos;
  logic [CW-1:0] cnt;
  logic [CW-1:0] idx;
  logic [CW-1:0] jdx;
  logic [CW-1:0] lo;
  logic [CW-1:0] hi;
  logic signed [ValW-1:0] cur;
  logic signed [ValW-1:0] prev;

  logic we;
  logic [AW-1:0] waddr;
  logic [ValW-1:0] wdata;
  logic [AW-1:0] raddr;
  logic [ValW-1:0] rdata;
  logic signed [ValW-1:0] rds;
  logic [CW-1:0] mid;

  logic [StatW-1:0] o_status;
  logic signed [ValW-1:0] o_read;
  logic [CW-1:0] o_fpos;
  logic o_flag;

  assign rds = signed'(rdata);
  assign mid = lo + ((hi - lo) >> 1);

  atss_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = (state == S_DONE);
  assign rsp.status = o_status;
  assign rsp.read_value = o_read;
  assign rsp.found_position = PosW'(o_fpos);
  assign rsp.flag = o_flag;
  assign rsp.count = PosW'(cnt);

  always_comb begin
    we = 1'b0;
    waddr = idx[AW-1:0];
    wdata = key;
    raddr = idx[AW-1:0];
    case (state)
      S_DISPATCH: begin
        if (act == ACT_APPEND && cnt != CW'(DEPTH)) begin
          we = 1'b1;
          waddr = cnt[AW-1:0];
        end
      end
      S_SHIFT_RD: raddr = (act == ACT_INSERT) ? AW'(idx - 1'b1) : AW'(idx + 1'b1);
      S_SHIFT_WR: begin
        we = 1'b1;
        wdata = rdata;
      end
      S_BS: raddr = mid[AW-1:0];
      S_SORT_CUR: raddr = idx[AW-1:0];
      S_SORT_CMP: begin
        raddr = AW'(jdx - 1'b1);
        if (jdx != '0 && idx != jdx) begin
          we = 1'b0;
        end
      end
      default: ;
    endcase
    if (state == S_WAIT && act == ACT_SORT) begin
      if (jdx == '0 || !(rds > cur)) begin
        we = 1'b1;
        waddr = jdx[AW-1:0];
        wdata = cur;
      end else begin
        we = 1'b1;
        waddr = jdx[AW-1:0];
        wdata = rdata;
      end
    end
    if (state == S_WAIT && act == ACT_INSERT && idx == pos) begin
      we = 1'b1;
      waddr = pos[AW-1:0];
      wdata = key;
    end
  end

  // S_WAIT is used as a generic "read data now valid" state for reads,
  // the insert's final write and sort. Shift: idx walks; write happens in S_SHIFT_WR.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            act <= action_t'(req.action);
            key <= req.value;
            pos <= CW'(req.position);
            o_status <= ST_OK;
            o_read <= '0;
            o_fpos <= '0;
            o_flag <= 1'b0;
            state <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          case (act)
            ACT_APPEND: begin
              if (cnt == CW'(DEPTH)) o_status <= ST_FULL;
              else cnt <= cnt + 1'b1;
              state <= S_DONE;
            end
            ACT_INSERT: begin
              if (cnt == CW'(DEPTH)) begin
                o_status <= ST_FULL;
                state <= S_DONE;
              end else if (pos > cnt) begin
                o_status <= ST_RANGE;
                state <= S_DONE;
              end else begin
                idx <= cnt;
                state <= (cnt == pos) ? S_WAIT : S_SHIFT_RD;
              end
            end
            ACT_REMOVE: begin
              if (pos >= cnt) begin
                o_status <= ST_RANGE;
                state <= S_DONE;
              end else begin
                idx <= pos;
                if (pos + 1'b1 == cnt) begin
                  cnt <= cnt - 1'b1;
                  state <= S_DONE;
                end else begin
                  state <= S_SHIFT_RD;
                end
              end
            end
            ACT_READ: begin
              if (pos >= cnt) begin
                o_status <= ST_RANGE;
                state <= S_DONE;
              end else begin
                idx <= pos;
                state <= S_RD;
              end
            end
            ACT_LSEARCH: begin
              o_fpos <= cnt;
              o_status <= ST_NOTFOUND;
              idx <= '0;
              state <= (cnt == '0) ? S_DONE : S_RD;
            end
            ACT_BSEARCH: begin
              o_fpos <= cnt;
              o_status <= ST_NOTFOUND;
              lo <= '0;
              hi <= cnt;
              state <= (cnt == '0) ? S_DONE : S_BS;
            end
            ACT_SORT: begin
              idx <= CW'(1);
              state <= (cnt > CW'(1)) ? S_SORT_CUR : S_DONE;
            end
            default: begin
              o_flag <= 1'b1;
              idx <= '0;
              state <= (cnt > CW'(1)) ? S_RD : S_DONE;
            end
          endcase
        end
        S_RD: begin
          // issue read at idx (raddr default), then look at it
          state <= (act == ACT_LSEARCH) ? S_LS : (act == ACT_CHECK) ? S_CHK : S_WAIT;
        end
        S_WAIT: begin
          case (act)
            ACT_READ: begin
              o_read <= rds;
              state <= S_DONE;
            end
            ACT_INSERT: begin
              cnt <= cnt + 1'b1;
              state <= S_DONE;
            end
            default: begin
              // sort inner step
              if (jdx == '0 || !(rds > cur)) begin
                if (idx + 1'b1 == cnt) state <= S_DONE;
                else begin
                  idx <= idx + 1'b1;
                  state <= S_SORT_CUR;
                end
              end else begin
                jdx <= jdx - 1'b1;
                state <= S_SORT_CMP;
              end
            end
          endcase
        end
        S_SHIFT_RD: state <= S_SHIFT_WR;
        S_SHIFT_WR: begin
          if (act == ACT_INSERT) begin
            idx <= idx - 1'b1;
            state <= (idx - 1'b1 == pos) ? S_WAIT : S_SHIFT_RD;
          end else begin
            idx <= idx + 1'b1;
            if (idx + CW'(2) == cnt) begin
              cnt <= cnt - 1'b1;
              state <= S_DONE;
            end else begin
              state <= S_SHIFT_RD;
            end
          end
        end
        S_LS: begin
          if (rds == key) begin
            o_fpos <= idx;
            o_status <= ST_OK;
            o_flag <= 1'b1;
            state <= S_DONE;
          end else if (idx + 1'b1 == cnt) begin
            state <= S_DONE;
          end else begin
            idx <= idx + 1'b1;
            state <= S_RD;
          end
        end
        S_BS: begin
          idx <= mid;
          state <= S_CHK;
        end
        S_CHK: begin
          if (act == ACT_BSEARCH) begin
            if (rds == key) begin
              o_fpos <= idx;
              o_status <= ST_OK;
              o_flag <= 1'b1;
              state <= S_DONE;
            end else begin
              if (rds > key) begin
                hi <= idx;
                state <= (lo < idx) ? S_BS : S_DONE;
              end else begin
                lo <= idx + 1'b1;
                state <= (idx + 1'b1 < hi) ? S_BS : S_DONE;
              end
            end
          end else begin
            if (idx != '0 && prev > rds) begin
              o_flag <= 1'b0;
              state <= S_DONE;
            end else if (idx + 1'b1 == cnt) begin
              state <= S_DONE;
            end else begin
              prev <= rds;
              idx <= idx + 1'b1;
              state <= S_RD;
            end
          end
        end
        S_SORT_CUR: begin
          jdx <= idx;
          state <= S_SORT_CMP;
        end
        S_SORT_CMP: begin
          if (jdx == idx) cur <= rds;
          if (jdx == '0) state <= S_WAIT;
          else state <= S_WAIT;
        end
        S_DONE: begin
          if (rsp.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) cnt <= CW'(DEPTH))
    else $error("count above capacity");
  assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ready) |=> rsp.valid)
    else $error("result dropped before taken");
  assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE && state != S_DISPATCH) |-> $stable(act))
    else $error("action changed during operation");
endmodule
